@@ rtl/usd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usd_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package usd_pkg;

	localparam int BYTE_W   = 8;
	localparam int CP_W     = 21;
	localparam int LEN_W    = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
	localparam logic [CP_W-1:0] MIN_LEN1    = 21'h000080;
	localparam logic [CP_W-1:0] MIN_LEN2    = 21'h000800;
	localparam logic [CP_W-1:0] MIN_LEN3    = 21'h010000;

	localparam logic [LEN_W-1:0] LEN_NONE = 2'd0;
	localparam logic [LEN_W-1:0] LEN_ONE  = 2'd1;
	localparam logic [LEN_W-1:0] LEN_TWO  = 2'd2;
	localparam logic [LEN_W-1:0] LEN_THREE = 2'd3;

	// one queued job: a run of invalid results, then an optional final result
	typedef struct packed {
		logic [1:0]      pre_cnt;
		logic            has_final;
		logic [CP_W-1:0] code_point;
		logic            is_invalid;
		logic            is_end;
	} usd_job_t;

endpackage

@@ rtl/usd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usd_front
// Byte classifier: tracks the pending sequence and turns each byte into a job.
// ----------------------------------------------------------------------------
module usd_front import usd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              job_valid,
	output usd_job_t          job
);

	logic [LEN_W-1:0] seq_len_q, seq_len_d;
	logic [1:0]       cont_q, cont_d;
	logic [CP_W-1:0]  accum_q, accum_d;

	logic             pending;
	logic             is_cont;
	logic [1:0]       cont_next;
	logic [CP_W-1:0]  shifted;
	logic [CP_W-1:0]  min_cp;
	logic             bad;

	assign pending   = (seq_len_q != LEN_NONE);
	assign is_cont   = (in_byte[7:6] == 2'b10);
	assign cont_next = cont_q + 2'd1;
	assign shifted   = {accum_q[CP_W-7:0], in_byte[5:0]};

	always_comb begin
		unique case (seq_len_q)
			LEN_ONE: min_cp = MIN_LEN1;
			LEN_TWO: min_cp = MIN_LEN2;
			default: min_cp = MIN_LEN3;
		endcase
	end

	assign bad = (shifted < min_cp) || (shifted > CP_MAX) ||
		((shifted >= SURR_LO) && (shifted <= SURR_HI));

	always_comb begin
		seq_len_d      = seq_len_q;
		cont_d         = cont_q;
		accum_d        = accum_q;
		job.pre_cnt    = 2'd0;
		job.has_final  = 1'b0;
		job.code_point = '0;
		job.is_invalid = 1'b0;
		job.is_end     = 1'b0;
		if (pending && is_cont) begin
			if (cont_next >= seq_len_q) begin
				seq_len_d     = LEN_NONE;
				cont_d        = 2'd0;
				accum_d       = '0;
				job.has_final = 1'b1;
				if (bad) begin
					job.is_invalid = 1'b1;
				end else begin
					job.code_point = shifted;
				end
			end else begin
				cont_d  = cont_next;
				accum_d = shifted;
			end
		end else begin
			// cut-off sequence: one invalid for the lead and each continuation
			if (pending) begin
				job.pre_cnt = cont_q + 2'd1;
			end
			seq_len_d = LEN_NONE;
			cont_d    = 2'd0;
			accum_d   = '0;
			priority if (in_byte == '0) begin
				job.has_final = 1'b1;
				job.is_end    = 1'b1;
			end else if (in_byte[7] == 1'b0) begin
				job.has_final  = 1'b1;
				job.code_point = CP_W'(in_byte);
			end else if (in_byte[7:5] == 3'b110) begin
				seq_len_d = LEN_ONE;
				accum_d   = CP_W'(in_byte[4:0]);
			end else if (in_byte[7:4] == 4'b1110) begin
				seq_len_d = LEN_TWO;
				accum_d   = CP_W'(in_byte[3:0]);
			end else if (in_byte[7:3] == 5'b11110) begin
				seq_len_d = LEN_THREE;
				accum_d   = CP_W'(in_byte[2:0]);
			end else begin
				job.has_final  = 1'b1;
				job.is_invalid = 1'b1;
			end
		end
	end

	assign job_valid = take && ((job.pre_cnt != 2'd0) || job.has_final);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q <= LEN_NONE;
			cont_q    <= 2'd0;
			accum_q   <= '0;
		end else if (take) begin
			seq_len_q <= seq_len_d;
			cont_q    <= cont_d;
			accum_q   <= accum_d;
		end
	end

endmodule

@@ rtl/usd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usd_queue
// Short job queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module usd_queue import usd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  usd_job_t wr_job,
	output logic     full,
	input  logic     rd_en,
	output usd_job_t rd_job,
	output logic     avail
);

	usd_job_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign avail  = (count_q != '0);
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/usd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usd_back
// Result sequencer: expands each job into results in the output register.
// ----------------------------------------------------------------------------
module usd_back import usd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_avail,
	input  usd_job_t        job,
	output logic            job_done,
	input  logic            pop,
	output logic            empty,
	output logic [CP_W-1:0] code_point,
	output logic            is_invalid,
	output logic            is_end,
	output logic            last_of_run
);

	logic            empty_q;
	logic [1:0]      done_q;
	logic [CP_W-1:0] cp_q;
	logic            inv_q;
	logic            end_q;
	logic            last_q;

	logic            load;
	logic            in_pre;
	logic            last_now;

	assign load     = job_avail && (empty_q || pop);
	assign in_pre   = (done_q < job.pre_cnt);
	assign last_now = in_pre ? ((done_q + 2'd1 == job.pre_cnt) && !job.has_final) : 1'b1;
	assign job_done = load && last_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= 1'b1;
			done_q  <= 2'd0;
		end else if (load) begin
			empty_q <= 1'b0;
			done_q  <= last_now ? 2'd0 : done_q + 2'd1;
		end else if (pop) begin
			empty_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= last_now;
			if (in_pre) begin
				cp_q  <= '0;
				inv_q <= 1'b1;
				end_q <= 1'b0;
			end else begin
				cp_q  <= job.code_point;
				inv_q <= job.is_invalid;
				end_q <= job.is_end;
			end
		end
	end

	assign empty       = empty_q;
	assign code_point  = cp_q;
	assign is_invalid  = inv_q;
	assign is_end      = end_q;
	assign last_of_run = last_q;

endmodule

@@ rtl/utf8_stream_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 to code point decoder with queue-style ports.
// A byte's job is queued before its first result enters the output register.
// Throughput: one byte per cycle while full is low; the result sequencer emits
// one result per cycle while pop keeps the output register free, so a cut-off
// sequence (up to four results) holds it. A job queue of four entries absorbs
// those bursts before full rises. Reset: arst_n clears the pending sequence and
// the queue, and marks the output register empty.
// ----------------------------------------------------------------------------
module utf8_stream_decoder import usd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              empty,
	input  logic              pop,
	output logic [CP_W-1:0]   code_point,
	output logic              is_invalid,
	output logic              is_end,
	output logic              last_of_run
);

	logic     take;
	logic     job_wr;
	usd_job_t job_in;
	usd_job_t job_head;
	logic     job_avail;
	logic     job_done;

	assign take = push && !full;

	usd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (in_byte),
		.job_valid (job_wr),
		.job       (job_in)
	);

	usd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_wr),
		.wr_job (job_in),
		.full   (full),
		.rd_en  (job_done),
		.rd_job (job_head),
		.avail  (job_avail)
	);

	usd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_avail   (job_avail),
		.job         (job_head),
		.job_done    (job_done),
		.pop         (pop),
		.empty       (empty),
		.code_point  (code_point),
		.is_invalid  (is_invalid),
		.is_end      (is_end),
		.last_of_run (last_of_run)
	);

endmodule

@@ sim/utf8_stream_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Streams UTF-8 bytes into the decoder and checks every code point result
// against a cycle-free decode model kept in the bench. Directed tests cover
// boundary values, malformed and cut-off sequences; a long random stream of
// mostly well-formed text with broken sequences and noise follows, with
// random idling on both sides.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;
	import usd_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int MAX_GAP        = 12;
	localparam int TOTAL_BYTES    = 460;
	localparam int TAIL_CYCLES    = 10;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            inv;
		logic            eot;
		logic            last;
	} cp_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [BYTE_W-1:0] in_byte = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [CP_W-1:0]   code_point;
	logic              is_invalid;
	logic              is_end;
	logic              last_of_run;

	// decode state of the bench model
	logic [LEN_W-1:0] dec_len = LEN_NONE;
	logic [LEN_W-1:0] dec_taken = '0;
	logic [CP_W-1:0]  dec_acc = '0;

	cp_result_t run_q[$];
	cp_result_t cp_expect_q[$];

	int  bytes_sent = 0;
	int  mismatch_cnt = 0;
	int  rx_gap = 0;
	int  stall_cycles = 0;
	bit  tx_idle_en = 1'b1;
	bit  rx_idle_en = 1'b1;

	utf8_stream_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_byte    (in_byte),
		.empty      (empty),
		.pop        (pop),
		.code_point (code_point),
		.is_invalid (is_invalid),
		.is_end     (is_end),
		.last_of_run(last_of_run)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic void add_result(input logic [CP_W-1:0] cp, input logic inv,
		input logic eot);
		cp_result_t r;
		r.cp   = cp;
		r.inv  = inv;
		r.eot  = eot;
		r.last = 1'b0;
		run_q.push_back(r);
	endfunction

	// byte seen with no sequence open
	function automatic void decode_fresh(input logic [7:0] b);
		if (b == 8'h00) begin
			add_result('0, 1'b0, 1'b1);
		end else if (!b[7]) begin
			add_result({13'd0, b}, 1'b0, 1'b0);
		end else if (b[7:5] == 3'b110) begin
			dec_len   = LEN_ONE;
			dec_acc   = {16'd0, b[4:0]};
			dec_taken = '0;
		end else if (b[7:4] == 4'b1110) begin
			dec_len   = LEN_TWO;
			dec_acc   = {17'd0, b[3:0]};
			dec_taken = '0;
		end else if (b[7:3] == 5'b11110) begin
			dec_len   = LEN_THREE;
			dec_acc   = {18'd0, b[2:0]};
			dec_taken = '0;
		end else begin
			add_result('0, 1'b1, 1'b0);
		end
	endfunction

	function automatic void predict_byte(input logic [7:0] b);
		logic [CP_W-1:0] min_cp;
		logic            bad;
		cp_result_t      r;
		if (dec_len == LEN_NONE) begin
			decode_fresh(b);
		end else if (b[7:6] == 2'b10) begin
			dec_acc   = {dec_acc[CP_W-7:0], b[5:0]};
			dec_taken = dec_taken + 2'd1;
			if (dec_taken >= dec_len) begin
				case (dec_len)
					LEN_ONE: min_cp = MIN_LEN1;
					LEN_TWO: min_cp = MIN_LEN2;
					default: min_cp = MIN_LEN3;
				endcase
				bad = (dec_acc < min_cp) || (dec_acc > CP_MAX) ||
					(dec_acc >= SURR_LO && dec_acc <= SURR_HI);
				add_result(bad ? '0 : dec_acc, bad, 1'b0);
				dec_len   = LEN_NONE;
				dec_taken = '0;
				dec_acc   = '0;
			end
		end else begin
			// cut off: one invalid for the lead, one per continuation taken
			add_result('0, 1'b1, 1'b0);
			for (int i = 0; i < dec_taken && i < 2; i++)
				add_result('0, 1'b1, 1'b0);
			dec_len   = LEN_NONE;
			dec_taken = '0;
			dec_acc   = '0;
			decode_fresh(b);
		end
		for (int i = 0; i < run_q.size(); i++) begin
			r = run_q[i];
			r.last = (i == run_q.size() - 1);
			cp_expect_q.push_back(r);
		end
		run_q.delete();
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
		@(negedge clk);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push    <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (full);
		predict_byte(b);
		bytes_sent++;
	endtask

	// encodes cp in len bytes and sends the first keep of them
	task automatic send_code(input logic [CP_W-1:0] cp, input int len, input int keep);
		logic [7:0] enc [4];
		case (len)
			1: enc[0] = {1'b0, cp[6:0]};
			2: begin
				enc[0] = {3'b110, cp[10:6]};
				enc[1] = {2'b10, cp[5:0]};
			end
			3: begin
				enc[0] = {4'b1110, cp[15:12]};
				enc[1] = {2'b10, cp[11:6]};
				enc[2] = {2'b10, cp[5:0]};
			end
			default: begin
				enc[0] = {5'b11110, cp[20:18]};
				enc[1] = {2'b10, cp[17:12]};
				enc[2] = {2'b10, cp[11:6]};
				enc[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < keep; i++)
			send_byte(enc[i]);
	endtask

	task automatic stop_push();
		@(negedge clk);
		push <= 1'b0;
	endtask

	task automatic wait_drained();
		stop_push();
		while (cp_expect_q.size() != 0)
			@(posedge clk);
	endtask

	// result side: pop after a random number of idle cycles
	always @(negedge clk) begin
		if (rx_gap != 0) begin
			pop <= 1'b0;
			rx_gap--;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		cp_result_t e;
		if (pop && !empty) begin
			if (cp_expect_q.size() == 0) begin
				$display("%0t: unexpected result cp=%h inv=%b end=%b last=%b", $time,
					code_point, is_invalid, is_end, last_of_run);
				mismatch_cnt++;
			end else begin
				e = cp_expect_q.pop_front();
				if (code_point !== e.cp) begin
					$display("%0t: code_point expected %h, got %h", $time, e.cp, code_point);
					mismatch_cnt++;
				end
				if (is_invalid !== e.inv) begin
					$display("%0t: is_invalid expected %b, got %b", $time, e.inv, is_invalid);
					mismatch_cnt++;
				end
				if (is_end !== e.eot) begin
					$display("%0t: is_end expected %b, got %b", $time, e.eot, is_end);
					mismatch_cnt++;
				end
				if (last_of_run !== e.last) begin
					$display("%0t: last_of_run expected %b, got %b", $time, e.last,
						last_of_run);
					mismatch_cnt++;
				end
			end
			rx_gap = rx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, stall_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic test_single_bytes();
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(8'h01);
	endtask

	task automatic test_valid_sequences();
		send_code(21'h000080, 2, 2);
		send_code(21'h00FFFF, 3, 3);
		send_code(21'h10FFFF, 4, 4);
	endtask

	task automatic test_invalid_sequences();
		send_code(21'h000000, 2, 2);   // overlong
		send_code(21'h00D800, 3, 3);   // surrogate
		send_code(21'h110000, 4, 4);   // above the last scalar value
	endtask

	task automatic test_stray_bytes();
		send_byte(8'h80);
		send_byte(8'hFF);
	endtask

	task automatic test_cut_off();
		// two continuations taken, then end of text: four results
		send_code(21'h010000, 4, 3);
		send_byte(8'h00);
		send_byte(8'hE2);
		send_byte(8'h41);
	endtask

	// sender never idles while the receiver stalls, so full must rise
	task automatic test_back_to_back();
		tx_idle_en = 1'b0;
		repeat (6) begin
			send_code(21'h010000, 4, 3);
			send_byte(8'hF8);
		end
		rx_idle_en = 1'b0;
		repeat (8)
			send_code(CP_W'($urandom_range(21'h000800, 21'h00FFFF)), 3, 3);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	task automatic test_drain_pause();
		send_code(21'h0020AC, 3, 3);
		send_byte(8'hC3);
		wait_drained();
		send_byte(8'hA9);
		send_byte(8'h0A);
	endtask

	task automatic send_random_code(input bit cut);
		int              len;
		logic [CP_W-1:0] cp;
		bit              wild;
		len  = cut ? $urandom_range(2, 4) : $urandom_range(1, 4);
		wild = ($urandom_range(0, 7) == 0);
		case (len)
			1: cp = CP_W'($urandom_range(1, 21'h00007F));
			2: cp = CP_W'(wild ? $urandom_range(0, 21'h00007F)
				: $urandom_range(21'h80, 21'h7FF));
			3: cp = CP_W'(wild ? $urandom_range(0, 21'h0007FF)
				: $urandom_range(21'h800, 21'hFFFF));
			default: cp = CP_W'(wild ? $urandom_range(0, 21'h1FFFFF)
				: $urandom_range(21'h010000, 21'h10FFFF));
		endcase
		if (cut) begin
			send_code(cp, len, $urandom_range(1, len - 1));
			send_byte(8'($urandom_range(0, 1) ? $urandom_range(0, 8'h7F)
				: $urandom_range(8'hC0, 8'hFF)));
		end else begin
			send_code(cp, len, len);
		end
	endtask

	task automatic test_random_stream();
		int pick;
		while (bytes_sent < TOTAL_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 58)
				send_random_code(1'b0);
			else if (pick < 72)
				send_random_code(1'b1);
			else if (pick < 86)
				send_byte(8'($urandom_range(0, 255)));
			else if (pick < 91)
				send_byte(8'h00);
			else if (pick < 95)
				send_byte(8'($urandom_range(8'h80, 8'hBF)));
			else if (pick < 98) begin
				tx_idle_en = ($urandom_range(0, 2) != 0);
				rx_idle_en = ($urandom_range(0, 2) != 0);
			end else
				wait_drained();
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		test_single_bytes();
		test_valid_sequences();
		test_invalid_sequences();
		test_stray_bytes();
		test_cut_off();
		test_back_to_back();
		test_drain_pause();
		test_random_stream();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
